// ===== hdl/stp_pkg.sv =====
// Package for the stabilizer tableau simulator: payload structs, row type,
// cell commands, controller states and the CHP row-sum function.
// No dependencies.
package stp_pkg;

    localparam int MAX_QUBITS = 64;
    localparam int TAB_ROWS   = 2 * MAX_QUBITS + 1;
    localparam int QW         = $clog2(MAX_QUBITS);
    localparam int CW         = $clog2(MAX_QUBITS + 1);
    localparam int RW         = $clog2(TAB_ROWS);

    localparam logic [2:0] OP_HAD   = 3'd0;
    localparam logic [2:0] OP_PHS   = 3'd1;
    localparam logic [2:0] OP_CNOT  = 3'd2;
    localparam logic [2:0] OP_MEAS  = 3'd3;
    localparam logic [2:0] OP_CLEAR = 3'd4;

    typedef struct packed {
        logic [2:0]    opcode;
        logic [QW-1:0] qubit_a;
        logic [QW-1:0] qubit_b;
        logic          random_outcome;
    } in_item_t;

    typedef struct packed {
        logic measured_value;
        logic was_deterministic;
    } out_item_t;

    typedef struct packed {
        logic [MAX_QUBITS-1:0] x;
        logic [MAX_QUBITS-1:0] z;
        logic                  p;
    } row_t;

    typedef enum logic [2:0] {
        CO_HOLD,
        CO_HAD,
        CO_PHS,
        CO_CNOT,
        CO_ROT,
        CO_SUM
    } cell_op_t;

    typedef struct packed {
        cell_op_t              op;
        logic [MAX_QUBITS-1:0] sel_a;
        logic [MAX_QUBITS-1:0] sel_b;
        logic [MAX_QUBITS-1:0] mask;
    } cell_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRE,
        ST_SCAN,
        ST_FIX,
        ST_WRSC,
        ST_RESTORE
    } state_t;

    // Row h becomes row i times row h; an odd phase sum leaves the phase alone.
    function automatic row_t row_sum(row_t h, row_t i, logic [MAX_QUBITS-1:0] m);
        logic [MAX_QUBITS-1:0] x1, z1, x2, z2, pl, mi;
        logic [CW-1:0]         cp, cm;
        logic [1:0]            s;
        row_t                  r;
        x1 = i.x & m;
        z1 = i.z & m;
        x2 = h.x & m;
        z2 = h.z & m;
        pl = (x1 & z1 & z2 & ~x2) | (x1 & ~z1 & z2 & x2) | (~x1 & z1 & x2 & ~z2);
        mi = (x1 & z1 & x2 & ~z2) | (x1 & ~z1 & z2 & ~x2) | (~x1 & z1 & x2 & z2);
        cp = CW'($countones(pl));
        cm = CW'($countones(mi));
        s  = {i.p, 1'b0} + {h.p, 1'b0} + cp[1:0] - cm[1:0];
        r  = h;
        if (s == 2'd0) begin
            r.p = 1'b0;
        end else if (s == 2'd2) begin
            r.p = 1'b1;
        end
        r.x = h.x ^ x1;
        r.z = h.z ^ z1;
        return r;
    endfunction

endpackage

// ===== hdl/stp_row_cell.sv =====
// One tableau row: applies gates, row sums against a broadcast pivot,
// and shifts in its neighbor's row when the ring rotates.
// Depends on stp_pkg.
module stp_row_cell (
    input  logic             aclk,
    input  stp_pkg::cell_cmd_t cmd,
    input  logic             en,
    input  logic             ld,
    input  stp_pkg::row_t    ld_row,
    input  stp_pkg::row_t    nb_row,
    input  stp_pkg::row_t    pivot,
    output stp_pkg::row_t    row
);
    import stp_pkg::*;

    row_t row_reg, row_next;
    logic xa, za, xb, zb;

    always_comb begin
        xa = |(row_reg.x & cmd.sel_a);
        za = |(row_reg.z & cmd.sel_a);
        xb = |(row_reg.x & cmd.sel_b);
        zb = |(row_reg.z & cmd.sel_b);
        row_next = row_reg;
        if (ld) begin
            row_next = ld_row;
        end else if (en) begin
            case (cmd.op)
                CO_HAD: begin
                    row_next.p = row_reg.p ^ (xa & za);
                    row_next.x = (row_reg.x & ~cmd.sel_a) | (za ? cmd.sel_a : '0);
                    row_next.z = (row_reg.z & ~cmd.sel_a) | (xa ? cmd.sel_a : '0);
                end
                CO_PHS: begin
                    row_next.p = row_reg.p ^ (xa & za);
                    row_next.z = row_reg.z ^ (xa ? cmd.sel_a : '0);
                end
                CO_CNOT: begin
                    row_next.p = row_reg.p ^ (xa & zb & (xb == za));
                    row_next.x = row_reg.x ^ (xa ? cmd.sel_b : '0);
                    row_next.z = row_reg.z ^ (zb ? cmd.sel_a : '0);
                end
                CO_ROT: begin
                    row_next = nb_row;
                end
                CO_SUM: begin
                    if (xa) begin
                        row_next = row_sum(row_reg, pivot, cmd.mask);
                    end
                end
                default: begin
                    row_next = row_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        row_reg <= row_next;
    end

    assign row = row_reg;

endmodule

// ===== hdl/stabilizer_tableau_simulator.sv =====
// Stabilizer tableau simulator: a ring of 2N+1 row cells with one controller
// that sequences measurements. Depends on stp_pkg and stp_row_cell.
//
// Hadamard, phase, CNOT and clear are applied from idle, which the block does
// not leave for them; operations on a qubit at or above the qubit count
// are accepted and dropped. A Z measurement turns the ring of 2N+1 active
// rows so that each stabilizer passes the fixed tap at row cell zero: a
// pre-turn brings the first stabilizer there, then the search (the
// deterministic product is built in the same pass), an update step, and
// the rest of the turn back home. The search stops at the first stabilizer
// with X on the qubit, whose outcome is random. The input is ready again in
// the same cycle that the result appears. A result still waiting in the output
// register holds a measurement at its final step until it transfers; the
// input is not taken while a measurement runs. Change the qubit count only
// when idle and follow it with a clear.
module stabilizer_tableau_simulator (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  stp_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output stp_pkg::out_item_t  m_data,
    input  logic                cfg_wr_en,
    input  logic [stp_pkg::CW-1:0] cfg_wr_data
);
    import stp_pkg::*;

    logic [CW-1:0]         cfg_reg;
    logic [CW-1:0]         n;
    logic [RW-1:0]         two_n;
    logic [RW-1:0]         sc;
    logic [MAX_QUBITS-1:0] mask;

    state_t                state_reg, state_next;
    logic [RW-1:0]         k_reg, k_next;
    logic [QW-1:0]         a_reg, a_next;
    logic                  oc_reg, oc_next;
    row_t                  acc_reg, acc_next;
    out_item_t             res_reg, res_next;
    logic                  m_valid_reg, m_valid_next;
    out_item_t             m_data_reg, m_data_next;

    row_t                  rows [TAB_ROWS];
    logic [TAB_ROWS-1:0]   xa_vec;
    cell_cmd_t             cmd;
    cell_op_t              cmd_op;
    logic                  do_clear, do_fix, do_wrsc, finish;
    logic                  a_ok, b_ok;
    row_t                  new_piv;

    always_comb begin
        if (cfg_reg == '0) begin
            n = CW'(1);
        end else if (cfg_reg > CW'(MAX_QUBITS)) begin
            n = CW'(MAX_QUBITS);
        end else begin
            n = cfg_reg;
        end
        two_n = {n, 1'b0};
        sc    = two_n - k_reg;
        mask  = (n >= CW'(MAX_QUBITS)) ? '1
                : ((MAX_QUBITS'(1) << n) - MAX_QUBITS'(1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CW'(MAX_QUBITS);
        end else if (cfg_wr_en) begin
            cfg_reg <= cfg_wr_data;
        end
    end

    assign a_ok = {1'b0, s_data.qubit_a} < n;
    assign b_ok = ({1'b0, s_data.qubit_b} < n) && (s_data.qubit_b != s_data.qubit_a);

    always_comb begin
        cmd.op    = cmd_op;
        cmd.sel_a = (state_reg == ST_IDLE) ? (MAX_QUBITS'(1) << s_data.qubit_a)
                                           : (MAX_QUBITS'(1) << a_reg);
        cmd.sel_b = MAX_QUBITS'(1) << s_data.qubit_b;
        cmd.mask  = mask;
        new_piv.x = '0;
        new_piv.z = MAX_QUBITS'(1) << a_reg;
        new_piv.p = oc_reg;
    end

    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        a_next     = a_reg;
        oc_next    = oc_reg;
        acc_next   = acc_reg;
        res_next   = res_reg;
        cmd_op     = CO_HOLD;
        do_clear   = 1'b0;
        do_fix     = 1'b0;
        do_wrsc    = 1'b0;
        finish     = 1'b0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (s_data.opcode)
                        OP_HAD: begin
                            if (a_ok) begin
                                cmd_op = CO_HAD;
                            end
                        end
                        OP_PHS: begin
                            if (a_ok) begin
                                cmd_op = CO_PHS;
                            end
                        end
                        OP_CNOT: begin
                            if (a_ok && b_ok) begin
                                cmd_op = CO_CNOT;
                            end
                        end
                        OP_MEAS: begin
                            if (a_ok) begin
                                state_next = ST_PRE;
                                k_next     = '0;
                                a_next     = s_data.qubit_a;
                                oc_next    = s_data.random_outcome;
                                acc_next   = '0;
                            end
                        end
                        OP_CLEAR: begin
                            do_clear = 1'b1;
                        end
                        default: begin
                            cmd_op = CO_HOLD;
                        end
                    endcase
                end
            end
            ST_PRE: begin
                if (k_reg == {1'b0, n}) begin
                    state_next = ST_SCAN;
                end else begin
                    cmd_op = CO_ROT;
                    k_next = k_reg + RW'(1);
                end
            end
            ST_SCAN: begin
                // Cell zero holds stabilizer n+r, cell n+1 holds destabilizer r.
                if (k_reg == two_n) begin
                    state_next = ST_WRSC;
                    res_next   = '{measured_value: acc_reg.p, was_deterministic: 1'b1};
                end else if (xa_vec[0]) begin
                    state_next = ST_FIX;
                end else begin
                    if (xa_vec[n + CW'(1)]) begin
                        acc_next = row_sum(acc_reg, rows[0], mask);
                    end
                    cmd_op = CO_ROT;
                    k_next = k_reg + RW'(1);
                end
            end
            ST_FIX: begin
                do_fix     = 1'b1;
                cmd_op     = CO_SUM;
                res_next   = '{measured_value: oc_reg, was_deterministic: 1'b0};
                state_next = ST_RESTORE;
            end
            ST_WRSC: begin
                do_wrsc    = 1'b1;
                state_next = ST_RESTORE;
            end
            ST_RESTORE: begin
                if (k_reg == '0) begin
                    if (!m_valid_reg || m_ready) begin
                        finish     = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else begin
                    cmd_op = CO_ROT;
                    k_next = (k_reg == two_n) ? '0 : k_reg + RW'(1);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        m_valid_next = finish | (m_valid_reg & ~m_ready);
        m_data_next  = finish ? res_reg : m_data_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg      <= a_next;
        oc_reg     <= oc_next;
        acc_reg    <= acc_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    for (genvar j = 0; j < TAB_ROWS; j++) begin : g_cell
        localparam logic [RW-1:0] J = RW'(j);
        logic          en, ld;
        logic [CW-1:0] nn;
        row_t          ld_row, clr_row, nb_row;

        always_comb begin
            nn        = aresetn ? n : CW'(MAX_QUBITS);
            clr_row.p = 1'b0;
            clr_row.x = (J < {1'b0, nn}) ? (MAX_QUBITS'(1) << J) : '0;
            clr_row.z = ((J >= {1'b0, nn}) && (J < {nn, 1'b0}))
                        ? (MAX_QUBITS'(1) << (J - {1'b0, nn})) : '0;
            ld = !aresetn || do_clear || (do_wrsc && (J == '0))
                 || (do_fix && ((J == '0) || (J == {1'b0, n} + RW'(1))));
            if (!aresetn || do_clear) begin
                ld_row = clr_row;
            end else if (J == '0) begin
                ld_row = do_fix ? new_piv : acc_reg;
            end else begin
                ld_row = rows[0];
            end
            if (do_fix) begin
                en = (J != '0) && (J <= two_n) && (J != sc);
            end else begin
                en = (J <= two_n);
            end
            nb_row = (J == two_n) ? rows[0] : rows[(j + 1) % TAB_ROWS];
        end

        assign xa_vec[j] = |(rows[j].x & cmd.sel_a);

        stp_row_cell u_cell (
            .aclk   (aclk),
            .cmd    (cmd),
            .en     (en),
            .ld     (ld),
            .ld_row (ld_row),
            .nb_row (nb_row),
            .pivot  (rows[0]),
            .row    (rows[j])
        );
    end

`ifndef SYNTHESIS
    a_idle_home: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (k_reg == '0))
        else $error("ring not in home position while idle");
    a_k_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (k_reg <= two_n))
        else $error("rotation count beyond ring length");
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> ($past(state_reg) == ST_RESTORE))
        else $error("result raised outside a measurement");
    a_busy_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready)
        else $error("input taken during a measurement");
`endif

endmodule
